// ===== hw/rtl/sus_pkg.sv =====
// ----------------------------------------------------------------------------
// sus_pkg
// Shared types and codes for the sorted unique set: request codes and the
// per-cycle update command that the top level sends down the row of cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sus_pkg;

   // request codes; the unused code behaves as a membership test
   typedef enum logic [1:0] {
      FUNC_TEST   = 2'd0,
      FUNC_ADD    = 2'd1,
      FUNC_REMOVE = 2'd2
   } func_type;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned COUNT_W = 5;

   typedef logic signed [VALUE_W-1:0] value_type;

   // update command broadcast to every cell in the shift cycle
   typedef struct packed {
      logic      insert;
      logic      remove;
      value_type value;
   } cell_cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sorted_unique_set.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_set
// Ascending set of distinct signed 32-bit values held in a row of cells,
// with membership test, add and remove requests.
// ----------------------------------------------------------------------------
// Each item has a compare cycle and a shift cycle: in the cycle it is accepted
// every cell compares its entry with the value, and in the next cycle the row
// shifts right (add) or left (remove) from the sorted position while busy is
// high. The result appears on the rsp_ ports for one cycle, flagged by
// rsp_strobe, in the cycle after that, and a new item may be started in that
// same cycle; no new item is taken while busy is high. Results cannot be held
// off by the receiver. rsp_count carries the low 5 bits of the count.
`default_nettype none

module sorted_unique_set #(
   parameter int unsigned CAPACITY = 16
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  wire  [1:0]          req_func,
   input  wire sus_pkg::value_type req_value,
   output logic                rsp_strobe,
   output logic                rsp_was_present,
   output logic                rsp_changed,
   output logic                rsp_full_reject,
   output logic [sus_pkg::COUNT_W-1:0] rsp_count
);
   import sus_pkg::*;

   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic                busy_ff;
   logic                accept;
   logic [1:0]          func_ff;
   value_type           value_ff;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       count_in;

   value_type           ent   [CAPACITY];
   logic [CAPACITY-1:0] less_vec;
   logic [CAPACITY-1:0] eq_vec;
   cell_cmd_type        cmd;

   logic present;
   logic full;
   logic do_add;
   logic reject;
   logic [CW+COUNT_W-1:0] count_wide;

   logic                rsp_strobe_ff;
   logic                rsp_present_ff;
   logic                rsp_changed_ff;
   logic                rsp_reject_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // request capture and shift-cycle flag
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         value_ff <= req_value;
      end
   end

   // decision from the registered compare flags
   always_comb begin
      present    = |eq_vec;
      full       = (count_ff == CW'(CAPACITY));
      do_add     = busy_ff && (func_ff == FUNC_ADD) && !present;
      reject     = do_add && full;
      cmd.insert = do_add && !full;
      cmd.remove = busy_ff && (func_ff == FUNC_REMOVE) && present;
      cmd.value  = value_ff;
      count_in   = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CW'(1);
      end
      count_wide = {{COUNT_W{1'b0}}, count_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      occ;
      logic      left_less;
      value_type left_entry;
      value_type right_entry;

      assign occ = (CW'(i) < count_ff);

      if (i == 0) begin : g_first
         assign left_less  = 1'b1;
         assign left_entry = cmd.value;
      end else begin : g_mid
         assign left_less  = less_vec[i-1];
         assign left_entry = ent[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_entry = ent[i];
      end else begin : g_inner
         assign right_entry = ent[i+1];
      end

      sus_cell u_cell (
         .clock       (clock),
         .cmp_en      (accept),
         .occupied    (occ),
         .cmp_value   (req_value),
         .cmd         (cmd),
         .left_entry  (left_entry),
         .left_less   (left_less),
         .right_entry (right_entry),
         .entry       (ent[i]),
         .less        (less_vec[i]),
         .equal       (eq_vec[i])
      );
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         rsp_present_ff <= present;
         rsp_changed_ff <= cmd.insert || cmd.remove;
         rsp_reject_ff  <= reject;
         rsp_count_ff   <= count_wide[COUNT_W-1:0];
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_was_present = rsp_present_ff;
   assign rsp_changed     = rsp_changed_ff;
   assign rsp_full_reject = rsp_reject_ff;
   assign rsp_count       = rsp_count_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sus_cell.sv =====
// ----------------------------------------------------------------------------
// sus_cell
// One slot of the sorted row. Compares its entry with the request value, then
// keeps its entry, takes the new value, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sus_cell (
   input  wire                  clock,
   input  wire                  cmp_en,
   input  wire                  occupied,
   input  wire sus_pkg::value_type    cmp_value,
   input  wire sus_pkg::cell_cmd_type cmd,
   input  wire sus_pkg::value_type    left_entry,
   input  wire                  left_less,
   input  wire sus_pkg::value_type    right_entry,
   output sus_pkg::value_type   entry,
   output logic                 less,
   output logic                 equal
);
   import sus_pkg::*;

   value_type entry_ff;
   value_type entry_in;
   logic      less_ff;
   logic      eq_ff;

   // compare stage: flags held for the shift cycle
   always_ff @(posedge clock) begin
      if (cmp_en) begin
         less_ff <= occupied && (entry_ff < cmp_value);
         eq_ff   <= occupied && (entry_ff == cmp_value);
      end
   end

   // shift stage: slots at or above the sorted position move
   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert && !less_ff) begin
         entry_in = left_less ? cmd.value : left_entry;
      end else if (cmd.remove && !less_ff) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign less  = less_ff;
   assign equal = eq_ff;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted unique set: a directed table of requests
// followed by random add/remove/test traffic over a small value pool, every
// result compared field by field with a typed expectation from the table or with an in-bench model of the set.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;

   import sus_pkg::*;

   localparam int CAPACITY     = 16;
   localparam int RANDOM_ITEMS = 1220;
   localparam int POOL_SIZE    = 20;
   localparam int STALL_LIMIT  = 1000;
   localparam int TAIL_CYCLES  = 8;
   localparam int DIRECTED_ROWS = 21;

   // unused request code, behaves as a membership test
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   localparam value_type VAL_MIN = value_type'(32'h8000_0000);
   localparam value_type VAL_MAX = value_type'(32'h7fff_ffff);
   localparam value_type VAL_NEG = value_type'(32'haaaa_aaaa);
   localparam value_type VAL_POS = value_type'(32'h5555_5555);

   typedef struct packed {
      logic               was_present;
      logic               changed;
      logic               full_reject;
      logic [COUNT_W-1:0] count;
   } set_outcome_type;

   typedef struct packed {
      logic [1:0]      func;
      value_type       value;
      int              reps;
      logic            typed;
      set_outcome_type outcome;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [1:0]         req_func = '0;
   value_type          req_value = '0;
   logic               busy;
   logic               rsp_strobe;
   logic               rsp_was_present;
   logic               rsp_changed;
   logic               rsp_full_reject;
   logic [COUNT_W-1:0] rsp_count;

   // typed expectation that travels with the item on offer
   logic               expect_typed = 1'b0;
   set_outcome_type    typed_outcome = '0;

   // model of the stored set
   value_type          set_vals [CAPACITY];
   int                 set_size = 0;

   set_outcome_type    pending_outcomes [$];
   value_type          value_pool [POOL_SIZE];
   stim_row_type       directed_rows [DIRECTED_ROWS];
   int                 mismatches = 0;
   int                 stall_cycles = 0;

   always #4 clock = ~clock;

   sorted_unique_set #(
      .CAPACITY (CAPACITY)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_was_present (rsp_was_present),
      .rsp_changed     (rsp_changed),
      .rsp_full_reject (rsp_full_reject),
      .rsp_count       (rsp_count)
   );

   // apply one request to the model set and return its outcome
   function automatic set_outcome_type apply_request(logic [1:0] f, value_type v);
      int              slot;
      logic            hit;
      set_outcome_type res;
      slot = 0;
      for (int i = 0; i < set_size; i++) begin
         if (set_vals[i] < v) slot++;
      end
      hit = (slot < set_size) && (set_vals[slot] == v);
      res = '0;
      res.was_present = hit;
      if (f == FUNC_ADD && !hit) begin
         if (set_size >= CAPACITY) begin
            res.full_reject = 1'b1;
         end else begin
            for (int i = set_size; i > slot; i--) set_vals[i] = set_vals[i-1];
            set_vals[slot] = v;
            set_size++;
            res.changed = 1'b1;
         end
      end else if (f == FUNC_REMOVE && hit) begin
         for (int i = slot; i + 1 < set_size; i++) set_vals[i] = set_vals[i+1];
         set_size--;
         res.changed = 1'b1;
      end
      res.count = COUNT_W'(set_size);
      return res;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         mismatches++;
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      end
   endfunction

   // result check, expectation capture and watchdog, all on pre-edge values
   always @(posedge clock) begin
      set_outcome_type got;
      set_outcome_type want;
      set_outcome_type predicted;
      if (!reset) begin
         if (rsp_strobe) begin
            got = {rsp_was_present, rsp_changed, rsp_full_reject, rsp_count};
            if (pending_outcomes.size() == 0) begin
               mismatches++;
               $display("%0t unexpected result: expected none actual %b", $time, got);
            end else begin
               want = pending_outcomes.pop_front();
               check_field("was_present", want.was_present, got.was_present);
               check_field("changed", want.changed, got.changed);
               check_field("full_reject", want.full_reject, got.full_reject);
               check_field("count", want.count, got.count);
            end
         end
         if (start && !busy) begin
            predicted = apply_request(req_func, req_value);
            pending_outcomes.push_back(expect_typed ? typed_outcome : predicted);
         end
         if (rsp_strobe || (start && !busy)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t watchdog expired", $time);
            $display("status: fail");
            $finish;
         end
      end
   end

   // hold an item on the request ports until the block takes it
   task automatic offer_item(logic [1:0] f, value_type v, logic typed,
                             set_outcome_type exp);
      start         <= 1'b1;
      req_func      <= f;
      req_value     <= v;
      expect_typed  <= typed;
      typed_outcome <= exp;
      do @(posedge clock); while (busy);
   endtask

   // occasional gap between items
   task automatic maybe_pause(bit quiet);
      if (!quiet && $urandom_range(0, 99) < 9) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   initial begin
      logic [1:0] f;
      value_type  v;
      int         roll;
      bit         grow;

      // func, value, repeat count (value steps by one), typed, expected outcome
      directed_rows = '{
         '{FUNC_TEST,   32'sd0,  1, 1'b1, {1'b0, 1'b0, 1'b0, 5'd0}},
         '{FUNC_REMOVE, 32'sd0,  1, 1'b1, {1'b0, 1'b0, 1'b0, 5'd0}},
         '{FUNC_SPARE,  32'sd0,  1, 1'b1, {1'b0, 1'b0, 1'b0, 5'd0}},
         '{FUNC_ADD,    VAL_MIN, 1, 1'b1, {1'b0, 1'b1, 1'b0, 5'd1}},
         '{FUNC_ADD,    VAL_MAX, 1, 1'b1, {1'b0, 1'b1, 1'b0, 5'd2}},
         '{FUNC_ADD,    VAL_MAX, 1, 1'b1, {1'b1, 1'b0, 1'b0, 5'd2}},
         '{FUNC_TEST,   VAL_MIN, 1, 1'b1, {1'b1, 1'b0, 1'b0, 5'd2}},
         '{FUNC_SPARE,  VAL_MAX, 1, 1'b1, {1'b1, 1'b0, 1'b0, 5'd2}},
         '{FUNC_ADD,    -32'sd1, 1, 1'b1, {1'b0, 1'b1, 1'b0, 5'd3}},
         '{FUNC_ADD,    32'sd0,  1, 1'b1, {1'b0, 1'b1, 1'b0, 5'd4}},
         '{FUNC_REMOVE, VAL_MIN, 1, 1'b1, {1'b1, 1'b1, 1'b0, 5'd3}},
         '{FUNC_REMOVE, VAL_MAX, 1, 1'b1, {1'b1, 1'b1, 1'b0, 5'd2}},
         '{FUNC_REMOVE, 32'sd5,  1, 1'b1, {1'b0, 1'b0, 1'b0, 5'd2}},
         '{FUNC_ADD,    VAL_POS, 1, 1'b0, '0},
         '{FUNC_ADD,    VAL_NEG, 1, 1'b0, '0},
         '{FUNC_ADD,    32'sd100, 12, 1'b0, '0},
         '{FUNC_ADD,    32'sd7,  1, 1'b1, {1'b0, 1'b0, 1'b1, 5'd16}},
         '{FUNC_ADD,    32'sd105, 1, 1'b1, {1'b1, 1'b0, 1'b0, 5'd16}},
         '{FUNC_REMOVE, 32'sd7,  1, 1'b1, {1'b0, 1'b0, 1'b0, 5'd16}},
         '{FUNC_REMOVE, VAL_NEG, 1, 1'b1, {1'b1, 1'b1, 1'b0, 5'd15}},
         '{FUNC_ADD,    32'sd7,  1, 1'b1, {1'b0, 1'b1, 1'b0, 5'd16}}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[r]) begin
         for (int k = 0; k < directed_rows[r].reps; k++) begin
            maybe_pause(1'b0);
            offer_item(directed_rows[r].func, value_type'(directed_rows[r].value + k),
                       directed_rows[r].typed, directed_rows[r].outcome);
         end
      end

      // random traffic: a small pool keeps hits, full sets and drains frequent
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 300 == 0) begin
            foreach (value_pool[p]) value_pool[p] = value_type'($urandom);
         end
         grow = ((n / 150) % 2) == 0;
         roll = $urandom_range(0, 99);
         if (roll < 5) f = FUNC_SPARE;
         else if (roll < 25) f = FUNC_TEST;
         else if (roll < (grow ? 80 : 45)) f = FUNC_ADD;
         else f = FUNC_REMOVE;
         if ($urandom_range(0, 99) < 80) v = value_pool[$urandom_range(0, POOL_SIZE-1)];
         else v = value_type'($urandom);
         maybe_pause(n >= 500 && n < 700);
         offer_item(f, v, 1'b0, '0);
      end
      start <= 1'b0;

      // drain outstanding results, then allow for stray strobes
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
hw/rtl/sus_pkg.sv
hw/rtl/sus_cell.sv
hw/rtl/sorted_unique_set.sv
tb/tb.sv
